>>> rtl/per_key_token_bucket_limiter_unit_assert.svh
// ---------------------------------------------------------------------------
// assertion macros for the per-key token bucket limiter
// ---------------------------------------------------------------------------
`ifndef PER_KEY_TOKEN_BUCKET_LIMITER_UNIT_ASSERT_SVH
`define PER_KEY_TOKEN_BUCKET_LIMITER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PTBL_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PTBL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/ptbl_pkg.sv
// ---------------------------------------------------------------------------
// ptbl_pkg
// shared constants and types of the per-key token bucket limiter
// ---------------------------------------------------------------------------
package ptbl_pkg;

  // table geometry
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  // field widths
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned TOK_W      = 32;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned LIMIT_W    = 7;
  localparam int unsigned LIM_W      = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int unsigned PROD_W     = 2 * TOK_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // one token in Q16.16
  localparam logic [TOK_W-1:0] ONE_TOKEN = 32'h0001_0000;

  // register reset values
  localparam logic [TOK_W-1:0]   RATE_RESET  = 32'h0001_0000;
  localparam logic [TOK_W-1:0]   BURST_RESET = 32'h000A_0000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REFILL_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LIMIT   = 2'd2;

  // outcome codes
  localparam logic [1:0] OUTCOME_ALLOWED    = 2'd0;
  localparam logic [1:0] OUTCOME_NO_TOKEN   = 2'd1;
  localparam logic [1:0] OUTCOME_TABLE_FULL = 2'd2;

  // request beat
  typedef struct packed {
    logic [KEY_W-1:0]  source_key;
    logic [TIME_W-1:0] now_ticks;
  } req_t;

  // result beat
  typedef struct packed {
    logic       allowed;
    logic [1:0] outcome;
  } res_t;

  // one table entry as stored in memory
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TOK_W-1:0]  tokens;
    logic [TIME_W-1:0] last_time;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // scan probe issued together with a memory read
  typedef struct packed {
    logic             go;
    logic             live;
    logic [IDX_W-1:0] idx;
  } probe_t;

  // per-entry verdict at the end of the evaluation pipe
  typedef struct packed {
    logic              go;
    logic              last;
    logic [IDX_W-1:0]  idx;
    logic              hit;
    logic              prunable;
    logic              free;
    logic              gt;
    logic              hi;
    logic [TOK_W-1:0]  tokens;
    logic [TIME_W-1:0] last_time;
    logic [PROD_W-1:0] prod;
  } verdict_t;

endpackage

>>> rtl/ptbl_ram.sv
// ---------------------------------------------------------------------------
// ptbl_ram
// single-port-write, single-port-read synchronous ram, registered read data
// ---------------------------------------------------------------------------
module ptbl_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 112
) (
  input  logic                                           clk_i,
  input  logic                                           we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]                               wdata_i,
  input  logic                                           re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr_i,
  output logic [WIDTH-1:0]                               rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> rtl/ptbl_eval.sv
// ---------------------------------------------------------------------------
// ptbl_eval
// three-stage pipe that judges each scanned entry: key match, elapsed time,
// refill product and the prune test
// ---------------------------------------------------------------------------
module ptbl_eval
  import ptbl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  probe_t            probe_i,
  input  entry_t            rd_data_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [TIME_W-1:0] now_i,
  input  logic [TOK_W-1:0]  rate_i,
  input  logic [TOK_W-1:0]  burst_i,
  output verdict_t          verdict_o
);

  // stage 1: probe aligned with read data
  probe_t s1_q;

  // stage 2: compare and subtract results
  logic              s2_go_q;
  logic [IDX_W-1:0]  s2_idx_q;
  logic              s2_live_q;
  logic              s2_hit_q;
  logic              s2_ge_q;
  logic              s2_gt_q;
  logic              s2_hi_q;
  logic [TOK_W-1:0]  s2_elo_q;
  logic [TOK_W-1:0]  s2_tokens_q;
  logic [TIME_W-1:0] s2_last_q;

  // stage 3: product
  logic              s3_go_q;
  logic [IDX_W-1:0]  s3_idx_q;
  logic              s3_live_q;
  logic              s3_hit_q;
  logic              s3_ge_q;
  logic              s3_gt_q;
  logic              s3_hi_q;
  logic [TOK_W-1:0]  s3_tokens_q;
  logic [TIME_W-1:0] s3_last_q;
  logic [PROD_W-1:0] s3_prod_q;

  logic [TIME_W:0]   diff;
  logic              key_eq;
  logic [PROD_W-1:0] prod;

  // elapsed time with borrow, key compare
  assign diff   = {1'b0, now_i} - {1'b0, rd_data_i.last_time};
  assign key_eq = (rd_data_i.key == key_i);
  // 32 by 32 product, operands zero-extended to the product width
  assign prod   = PROD_W'(s2_elo_q) * PROD_W'(rate_i);

  // pipe valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q    <= '0;
      s2_go_q <= 1'b0;
      s3_go_q <= 1'b0;
    end else begin
      s1_q    <= probe_i;
      s2_go_q <= s1_q.go;
      s3_go_q <= s2_go_q;
    end
  end

  // pipe payload
  always_ff @(posedge clk_i) begin
    s2_idx_q    <= s1_q.idx;
    s2_live_q   <= s1_q.live;
    s2_hit_q    <= s1_q.live & key_eq;
    s2_ge_q     <= ~diff[TIME_W];
    s2_gt_q     <= ~diff[TIME_W] & (diff[TIME_W-1:0] != '0);
    s2_hi_q     <= (diff[TIME_W-1:TOK_W] != '0);
    s2_elo_q    <= diff[TOK_W-1:0];
    s2_tokens_q <= rd_data_i.tokens;
    s2_last_q   <= rd_data_i.last_time;

    s3_idx_q    <= s2_idx_q;
    s3_live_q   <= s2_live_q;
    s3_hit_q    <= s2_hit_q;
    s3_ge_q     <= s2_ge_q;
    s3_gt_q     <= s2_gt_q;
    s3_hi_q     <= s2_hi_q;
    s3_tokens_q <= s2_tokens_q;
    s3_last_q   <= s2_last_q;
    s3_prod_q   <= prod;
  end

  // verdict: idle long enough to be full again means prunable
  always_comb begin
    verdict_o.go        = s3_go_q;
    verdict_o.last      = (s3_idx_q == IDX_W'(TABLE_DEPTH - 1));
    verdict_o.idx       = s3_idx_q;
    verdict_o.hit       = s3_hit_q;
    verdict_o.prunable  = s3_live_q & s3_ge_q &
                          (s3_hi_q | (s3_prod_q >= {{TOK_W{1'b0}}, burst_i}));
    verdict_o.free      = ~s3_live_q;
    verdict_o.gt        = s3_gt_q;
    verdict_o.hi        = s3_hi_q;
    verdict_o.tokens    = s3_tokens_q;
    verdict_o.last_time = s3_last_q;
    verdict_o.prod      = s3_prod_q;
  end

endmodule

>>> rtl/per_key_token_bucket_limiter_unit.sv
// each request walks the whole table memory through its single read port and
// then decides; an insert or a refusal ends there, while a key already held
// takes an add step and a spend step before done; one request at a time, a
// new start is taken only while busy_o is low
// reset: valid bits, entry count and registers return to their reset values
// at once; the result strobe cannot be held off by the receiver
// ---------------------------------------------------------------------------
// per_key_token_bucket_limiter_unit
// per-key token bucket rate limiter with a memory-held bucket table
// ---------------------------------------------------------------------------
`include "per_key_token_bucket_limiter_unit_assert.svh"

module per_key_token_bucket_limiter_unit
  import ptbl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  req_t                  req_i,
  output logic                  busy_o,
  output logic                  done_o,
  output res_t                  result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_ADD    = 5'b01000,
    ST_SPEND  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [TOK_W-1:0]   rate_q;
  logic [TOK_W-1:0]   burst_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [TOK_W-1:0]   eff_rate;
  logic [TOK_W-1:0]   eff_burst;
  logic [LIM_W-1:0]   lim_raw;
  logic [LIM_W-1:0]   eff_limit;

  // table bookkeeping
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [CNT_W-1:0]       scan_cnt_q, scan_cnt_d;

  // request and result
  req_t req_q;
  logic done_q, done_d;
  res_t result_q, result_d;
  logic accept;

  // scan accumulation
  logic                   found_q;
  logic                   have_free_q;
  logic                   have_fp_q;
  logic [CNT_W-1:0]       prune_cnt_q;
  logic [TABLE_DEPTH-1:0] prune_vec_q;
  logic [IDX_W-1:0]       free_idx_q;
  logic [IDX_W-1:0]       fp_idx_q;
  logic [IDX_W-1:0]       hit_idx_q;
  logic [TOK_W-1:0]       hit_tokens_q;
  logic [TIME_W-1:0]      hit_last_q;
  logic                   hit_gt_q;
  logic                   hit_hi_q;
  logic [PROD_W-1:0]      hit_prod_q;
  logic [TOK_W-1:0]       add_q, add_d;

  // memory and eval pipe
  logic             issue;
  logic [IDX_W-1:0] rd_addr;
  probe_t           probe;
  entry_t           rd_data;
  verdict_t         verdict;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  // decide and spend helpers
  logic              do_prune;
  logic [CNT_W-1:0]  cnt_after;
  logic              slot_ok;
  logic [IDX_W-1:0]  slot;
  logic [TOK_W:0]    sum;
  logic [TOK_W-1:0]  refilled;
  logic [TIME_W-1:0] new_last;

  assign accept = start_i & ~busy_o;
  assign busy_o = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

  // effective register values
  assign eff_rate  = (rate_q == '0) ? ONE_TOKEN : rate_q;
  assign eff_burst = (burst_q >= ONE_TOKEN) ? burst_q : ONE_TOKEN;
  assign lim_raw   = LIM_W'(limit_q);
  always_comb begin
    if (limit_q == '0) begin
      eff_limit = LIM_W'(1);
    end else if (lim_raw > LIM_W'(TABLE_DEPTH)) begin
      eff_limit = LIM_W'(TABLE_DEPTH);
    end else begin
      eff_limit = lim_raw;
    end
  end

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= RATE_RESET;
      burst_q <= BURST_RESET;
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REFILL_RATE: rate_q  <= cfg_data_i[TOK_W-1:0];
        CFG_BURST_LIMIT: burst_q <= cfg_data_i[TOK_W-1:0];
        CFG_KEY_LIMIT:   limit_q <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // scan read issue
  assign issue   = (state_q == ST_SCAN) && (scan_cnt_q < CNT_W'(TABLE_DEPTH));
  assign rd_addr = scan_cnt_q[IDX_W-1:0];

  always_comb begin
    probe.go   = issue;
    probe.live = valid_q[rd_addr];
    probe.idx  = rd_addr;
  end

  ptbl_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (issue),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  ptbl_eval u_eval (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .probe_i   (probe),
    .rd_data_i (rd_data),
    .key_i     (req_q.source_key),
    .now_i     (req_q.now_ticks),
    .rate_i    (eff_rate),
    .burst_i   (eff_burst),
    .verdict_o (verdict)
  );

  // scan accumulation flags and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      have_free_q <= 1'b0;
      have_fp_q   <= 1'b0;
      prune_cnt_q <= '0;
    end else if (accept) begin
      found_q     <= 1'b0;
      have_free_q <= 1'b0;
      have_fp_q   <= 1'b0;
      prune_cnt_q <= '0;
    end else if (verdict.go) begin
      if (verdict.hit) begin
        found_q <= 1'b1;
      end
      if (verdict.free) begin
        have_free_q <= 1'b1;
      end
      if (verdict.free | verdict.prunable) begin
        have_fp_q <= 1'b1;
      end
      prune_cnt_q <= prune_cnt_q + CNT_W'(verdict.prunable);
    end
  end

  // scan accumulation payload: first hit, lowest free slots, prune marks
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (verdict.go) begin
      prune_vec_q[verdict.idx] <= verdict.prunable;
      if (verdict.hit && !found_q) begin
        hit_idx_q    <= verdict.idx;
        hit_tokens_q <= verdict.tokens;
        hit_last_q   <= verdict.last_time;
        hit_gt_q     <= verdict.gt;
        hit_hi_q     <= verdict.hi;
        hit_prod_q   <= verdict.prod;
      end
      if (verdict.free && !have_free_q) begin
        free_idx_q <= verdict.idx;
      end
      if ((verdict.free | verdict.prunable) && !have_fp_q) begin
        fp_idx_q <= verdict.idx;
      end
    end
    add_q <= add_d;
  end

  // miss path: prune when at the limit, then pick the lowest open slot
  assign do_prune  = (LIM_W'(cnt_q) >= eff_limit);
  assign cnt_after = do_prune ? (cnt_q - prune_cnt_q) : cnt_q;
  assign slot_ok   = do_prune ? have_fp_q : have_free_q;
  assign slot      = do_prune ? fp_idx_q : free_idx_q;

  // hit path: refill saturating at burst
  assign sum      = {1'b0, hit_tokens_q} + {1'b0, add_q};
  assign refilled = !hit_gt_q ? hit_tokens_q :
                    (sum > {1'b0, eff_burst}) ? eff_burst : sum[TOK_W-1:0];
  assign new_last = hit_gt_q ? req_q.now_ticks : hit_last_q;

  // sequencer
  always_comb begin
    state_d    = state_q;
    scan_cnt_d = scan_cnt_q;
    valid_d    = valid_q;
    cnt_d      = cnt_q;
    done_d     = 1'b0;
    result_d   = result_q;
    add_d      = add_q;
    mem_we     = 1'b0;
    mem_waddr  = hit_idx_q;
    mem_wdata.key       = req_q.source_key;
    mem_wdata.tokens    = refilled;
    mem_wdata.last_time = new_last;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          scan_cnt_d = '0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          scan_cnt_d = scan_cnt_q + CNT_W'(1);
        end
        if (verdict.go && verdict.last) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (found_q) begin
          state_d = ST_ADD;
        end else begin
          if (do_prune) begin
            valid_d = valid_q & ~prune_vec_q;
          end
          if ((LIM_W'(cnt_after) >= eff_limit) || !slot_ok) begin
            cnt_d            = cnt_after;
            result_d.allowed = 1'b0;
            result_d.outcome = OUTCOME_TABLE_FULL;
          end else begin
            // new bucket starts full and spends one token at once
            valid_d[slot]       = 1'b1;
            cnt_d               = cnt_after + CNT_W'(1);
            mem_we              = 1'b1;
            mem_waddr           = slot;
            mem_wdata.tokens    = eff_burst - ONE_TOKEN;
            mem_wdata.last_time = req_q.now_ticks;
            result_d.allowed    = 1'b1;
            result_d.outcome    = OUTCOME_ALLOWED;
          end
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_ADD: begin
        if (hit_hi_q || (hit_prod_q > {{TOK_W{1'b0}}, eff_burst})) begin
          add_d = eff_burst;
        end else begin
          add_d = hit_prod_q[TOK_W-1:0];
        end
        state_d = ST_SPEND;
      end
      ST_SPEND: begin
        mem_we = 1'b1;
        if (refilled < ONE_TOKEN) begin
          result_d.allowed = 1'b0;
          result_d.outcome = OUTCOME_NO_TOKEN;
        end else begin
          mem_wdata.tokens = refilled - ONE_TOKEN;
          result_d.allowed = 1'b1;
          result_d.outcome = OUTCOME_ALLOWED;
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_cnt_q <= '0;
      valid_q    <= '0;
      cnt_q      <= '0;
      done_q     <= 1'b0;
      result_q   <= '0;
    end else begin
      state_q    <= state_d;
      scan_cnt_q <= scan_cnt_d;
      valid_q    <= valid_d;
      cnt_q      <= cnt_d;
      done_q     <= done_d;
      result_q   <= result_d;
    end
  end

  // checks
  `PTBL_ASSERT(a_cnt_matches_valid, 1'b1, cnt_q == CNT_W'($countones(valid_q)), "count off")
  `PTBL_ASSERT(a_we_in_commit, mem_we, state_q == ST_DECIDE || state_q == ST_SPEND, "stray write")
  `PTBL_ASSERT_NEXT(a_accept_busy, accept, busy_o && !done_o, "accepted beat not busy")
  `PTBL_ASSERT(a_done_idle, done_o, !busy_o, "result beat while busy")
  `PTBL_ASSERT(a_allowed_code, done_o, result_o.allowed == (result_o.outcome == OUTCOME_ALLOWED), "bad code")

endmodule
